/* rtl/rlde_pkg.sv */
// Shared types, codes and constant tables for the ring line direction estimator.
`timescale 1ns / 1ps
`default_nettype none

package rlde_pkg;

    // Fixed field widths of the stream channels
    localparam int CHANNEL_W   = 5;
    localparam int VALUE_W     = 12;
    localparam int MAP_W       = 32;
    localparam int COUNT_W     = 6;
    localparam int ANGLE_W     = 11;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 56;

    localparam int THRESHOLD_RESET = 1000;
    localparam int NO_ANGLE        = 1023;

    // Angle arithmetic: angles in units of 2^-16 degree, sums scaled by 2^20
    localparam int DEG_SHIFT    = 16;
    localparam int DEG_ONE      = 65536;
    localparam int SCALE_SHIFT  = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int ROM_FRAC     = 14;
    localparam int RING_STEPS   = 32;

    typedef enum logic {
        OP_SAMPLE    = 1'b0,
        OP_THRESHOLD = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ANGLE,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_ITER,
        CS_SUB,
        CS_WRAP,
        CS_TRUNC
    } cordic_state_t;

    typedef struct packed {
        logic sample;
        logic thr_write;
        logic clear;
    } acc_cmd_t;

    typedef struct packed {
        logic prev_online;
        logic sums_nonzero;
    } acc_status_t;

    localparam int COS_Q14 [RING_STEPS] = '{
        16384, 16083, 15191, 13741, 11786, 9397, 6664, 3686,
        572, -2563, -5604, -8438, -10963, -13085, -14726, -15826,
        -16344, -16262, -15582, -14330, -12551, -10311, -7692, -4790,
        -1713, 1428, 4516, 7438, 10087, 12365, 14189, 15491
    };

    localparam int SIN_Q14 [RING_STEPS] = '{
        0, 3126, 6138, 8923, 11381, 13421, 14968, 15964,
        16374, 16182, 15396, 14044, 12176, 9860, 7182, 4240,
        1143, -1997, -5063, -7943, -10531, -12733, -14466, -15668,
        -16294, -16322, -15749, -14598, -12911, -10749, -8192, -5334
    };

    localparam int ATAN_DEG16 [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    // Brings a Q1.14 table value to frac_bits fraction bits, rounding half
    // away from zero when bits are dropped.
    function automatic int trig_rescale(input int v, input int frac_bits);
        int sh;
        int m;
        sh = frac_bits - ROM_FRAC;
        if (sh >= 0) begin
            return v <<< sh;
        end
        m = (v < 0) ? -v : v;
        m = (m + ((1 << (-sh)) >> 1)) >> (-sh);
        return (v < 0) ? -m : m;
    endfunction

endpackage

`default_nettype wire

/* rtl/rlde_frame_acc.sv */
// Threshold table, direction table and per-frame hit accumulators.
`timescale 1ns / 1ps
`default_nettype none

module rlde_frame_acc #(
    parameter int SENSOR_COUNT   = 32,
    parameter int SAMPLE_BITS    = 12,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire rlde_pkg::acc_cmd_t                   cmd,
    input  wire logic [rlde_pkg::CHANNEL_W-1:0]       channel,
    input  wire logic [rlde_pkg::VALUE_W-1:0]         value,
    output logic [SENSOR_COUNT-1:0]                   hit_map,
    output logic [$clog2(SENSOR_COUNT+1)-1:0]         hit_count,
    output logic signed [TRIG_FRAC_BITS+6:0]          sum_cos,
    output logic signed [TRIG_FRAC_BITS+6:0]          sum_sin,
    output rlde_pkg::acc_status_t                     status
);
    import rlde_pkg::*;

    localparam int IDX_W = $clog2(SENSOR_COUNT);
    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int SW    = TRIG_FRAC_BITS + 7;

    logic [SAMPLE_BITS-1:0]   thr_reg [SENSOR_COUNT];
    logic signed [TW-1:0]     cos_rom [SENSOR_COUNT];
    logic signed [TW-1:0]     sin_rom [SENSOR_COUNT];

    logic [SENSOR_COUNT-1:0]  map_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [SW-1:0]     cos_sum_reg;
    logic signed [SW-1:0]     sin_sum_reg;
    logic                     prev_online_reg;

    logic [IDX_W-1:0]         idx;
    logic                     in_range;
    logic [SAMPLE_BITS-1:0]   sample_val;
    logic                     hit;

    genvar g;
    generate
        for (g = 0; g < SENSOR_COUNT; g++) begin : g_rom
            assign cos_rom[g] = TW'(trig_rescale(COS_Q14[g], TRIG_FRAC_BITS));
            assign sin_rom[g] = TW'(trig_rescale(SIN_Q14[g], TRIG_FRAC_BITS));
        end
    endgenerate

    assign idx        = channel[IDX_W-1:0];
    assign in_range   = ({1'b0, channel} < (CHANNEL_W + 1)'(SENSOR_COUNT));
    assign sample_val = SAMPLE_BITS'(value);

    // Only the first hit of a channel within a frame counts.
    assign hit = cmd.sample && in_range && (sample_val > thr_reg[idx]) && !map_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                thr_reg[i] <= SAMPLE_BITS'(THRESHOLD_RESET);
            end
        end else if (cmd.thr_write && in_range) begin
            thr_reg[idx] <= sample_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg         <= '0;
            count_reg       <= '0;
            cos_sum_reg     <= '0;
            sin_sum_reg     <= '0;
            prev_online_reg <= 1'b0;
        end else if (cmd.clear) begin
            prev_online_reg <= (count_reg != '0);
            map_reg         <= '0;
            count_reg       <= '0;
            cos_sum_reg     <= '0;
            sin_sum_reg     <= '0;
        end else if (hit) begin
            map_reg[idx] <= 1'b1;
            count_reg    <= count_reg + CNT_W'(1);
            cos_sum_reg  <= cos_sum_reg + SW'(cos_rom[idx]);
            sin_sum_reg  <= sin_sum_reg + SW'(sin_rom[idx]);
        end
    end

    assign hit_map             = map_reg;
    assign hit_count           = count_reg;
    assign sum_cos             = cos_sum_reg;
    assign sum_sin             = sin_sum_reg;
    assign status.prev_online  = prev_online_reg;
    assign status.sums_nonzero = (cos_sum_reg != '0) && (sin_sum_reg != '0);

endmodule

`default_nettype wire

/* rtl/rlde_cordic.sv */
// Iterative CORDIC vectoring unit that turns the two sums into a line angle.
`timescale 1ns / 1ps
`default_nettype none

module rlde_cordic #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [TRIG_FRAC_BITS+6:0]     sum_cos,
    input  wire logic signed [TRIG_FRAC_BITS+6:0]     sum_sin,
    output logic                                      done,
    output logic signed [rlde_pkg::ANGLE_W-1:0]       angle
);
    import rlde_pkg::*;

    localparam int SW     = TRIG_FRAC_BITS + 7;
    localparam int XW     = TRIG_FRAC_BITS + 29;
    localparam int ZW     = 28;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic signed [ZW-1:0] Z_180    = ZW'(180 * DEG_ONE);
    localparam logic signed [ZW-1:0] Z_270    = ZW'(270 * DEG_ONE);
    localparam logic signed [ZW-1:0] Z_360    = ZW'(360 * DEG_ONE);
    localparam logic signed [ZW-1:0] DEG_FRAC = ZW'(DEG_ONE - 1);

    cordic_state_t          state_reg, state_next;
    logic [STEP_W-1:0]      iter_reg, iter_next;
    logic signed [XW-1:0]   x_reg, x_next;
    logic signed [XW-1:0]   y_reg, y_next;
    logic signed [ZW-1:0]   z_reg, z_next;

    logic signed [XW-1:0]   cx_ext;
    logic signed [XW-1:0]   cy_ext;
    logic signed [XW-1:0]   x_sh;
    logic signed [XW-1:0]   y_sh;
    logic signed [ZW-1:0]   atan_step;
    logic                   y_pos;
    logic signed [ZW-1:0]   z_round;

    assign cx_ext    = XW'(sum_cos) <<< SCALE_SHIFT;
    assign cy_ext    = XW'(sum_sin) <<< SCALE_SHIFT;
    assign x_sh      = x_reg >>> iter_reg;
    assign y_sh      = y_reg >>> iter_reg;
    assign atan_step = ZW'(ATAN_DEG16[iter_reg]);
    assign y_pos     = !y_reg[XW-1] && (y_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    iter_next  = '0;
                    state_next = CS_ITER;
                    // A vector in the left half plane is mirrored through the origin
                    // and starts half a turn away.
                    if (sum_cos[SW-1]) begin
                        x_next = -cx_ext;
                        y_next = -cy_ext;
                        z_next = sum_sin[SW-1] ? -Z_180 : Z_180;
                    end else begin
                        x_next = cx_ext;
                        y_next = cy_ext;
                        z_next = '0;
                    end
                end
            end
            CS_ITER: begin
                if (y_pos) begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_step;
                end else begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_step;
                end
                iter_next = iter_reg + STEP_W'(1);
                if (iter_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = CS_SUB;
                end
            end
            CS_SUB: begin
                z_next     = Z_270 - z_reg;
                state_next = CS_WRAP;
            end
            CS_WRAP: begin
                if (z_reg < -Z_180) begin
                    z_next = z_reg + Z_360;
                end else if (z_reg >= Z_180) begin
                    z_next = z_reg - Z_360;
                end
                state_next = CS_TRUNC;
            end
            CS_TRUNC: begin
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Biasing negative angles before the shift gives truncation toward zero.
    assign z_round = z_reg + (z_reg[ZW-1] ? DEG_FRAC : ZW'(0));
    assign angle   = z_round[DEG_SHIFT +: ANGLE_W];
    assign done    = (state_reg == CS_TRUNC);

endmodule

`default_nettype wire

/* rtl/ring_line_direction_estimator.sv */
// Top level of the ring line direction estimator: control sequencer and result register.
//
// Input stream: one transfer per item. s_tuser[0] selects a sensor sample or a
// threshold write, s_tdata carries the channel and the value, s_tlast marks the
// last sample of a frame. Threshold writes and samples without s_tlast give no
// result and are taken one per cycle while s_tready is high.
// Output stream: one transfer per frame, carrying the hit bitmap, the hit count,
// the any-online flag and the line angle in whole degrees (1023 when no angle).
// Sequence: after a frame-end sample the sequencer checks whether an angle is needed;
// if so the iterative CORDIC runs its 16 iterations of adder and shifter, then its
// subtract, wrap and truncate steps; without an angle it goes straight to the output.
// s_tready is low from the frame-end transfer until the result is loaded into
// the output register, so no item is taken while a frame end is in progress.
// A result waiting on m_tready does not block samples, but the next frame end
// waits until the output register is free.
// Reset (aresetn low, synchronous) sets every threshold to 1000, clears the
// accumulators and the previous-frame flag and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module ring_line_direction_estimator #(
    parameter int SENSOR_COUNT   = 32,
    parameter int SAMPLE_BITS    = 12,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // channel [4:0], value [16:5], zero padding [23:17]
    input  wire logic [rlde_pkg::S_DATA_W-1:0]     s_tdata,
    // opcode [0]
    input  wire logic [0:0]                        s_tuser,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // online_map [31:0], online_count [37:32], any_online [38],
    // line_angle [49:39], zero padding [55:50]
    output logic [rlde_pkg::M_DATA_W-1:0]          m_tdata
);
    import rlde_pkg::*;

    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    localparam int SW    = TRIG_FRAC_BITS + 7;

    top_state_t                 state_reg, state_next;
    logic                       m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]        m_data_reg;
    logic signed [ANGLE_W-1:0]  ang_reg;

    logic                       accept;
    logic                       is_sample;
    logic                       out_load;
    logic                       cordic_start;
    logic                       cordic_done;
    logic signed [ANGLE_W-1:0]  cordic_angle;

    acc_cmd_t                   acc_cmd;
    acc_status_t                acc_status;
    logic [SENSOR_COUNT-1:0]    acc_map;
    logic [CNT_W-1:0]           acc_count;
    logic signed [SW-1:0]       acc_cos;
    logic signed [SW-1:0]       acc_sin;

    logic [MAP_W-1:0]           out_map;
    logic [COUNT_W-1:0]         out_count;
    logic                       out_any;
    logic [ANGLE_W-1:0]         out_angle;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_sample = (op_t'(s_tuser[0]) == OP_SAMPLE);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    assign acc_cmd.sample    = accept && is_sample;
    assign acc_cmd.thr_write = accept && !is_sample;
    assign acc_cmd.clear     = out_load;

    assign cordic_start = (state_reg == ST_CHECK) && acc_status.prev_online
                          && acc_status.sums_nonzero;

    rlde_frame_acc #(
        .SENSOR_COUNT   (SENSOR_COUNT),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_frame_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (acc_cmd),
        .channel   (s_tdata[CHANNEL_W-1:0]),
        .value     (s_tdata[CHANNEL_W +: VALUE_W]),
        .hit_map   (acc_map),
        .hit_count (acc_count),
        .sum_cos   (acc_cos),
        .sum_sin   (acc_sin),
        .status    (acc_status)
    );

    rlde_cordic #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .sum_cos (acc_cos),
        .sum_sin (acc_sin),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && is_sample && s_tlast) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = cordic_start ? ST_ANGLE : ST_OUT;
            end
            ST_ANGLE: begin
                if (cordic_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_CHECK) && !cordic_start) begin
            ang_reg <= ANGLE_W'(NO_ANGLE);
        end else if ((state_reg == ST_ANGLE) && cordic_done) begin
            ang_reg <= cordic_angle;
        end
        if (out_load) begin
            m_data_reg <= M_DATA_W'({ang_reg, (acc_count != '0), COUNT_W'(acc_count),
                                     MAP_W'(acc_map)});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign out_map   = m_data_reg[MAP_W-1:0];
    assign out_count = m_data_reg[MAP_W +: COUNT_W];
    assign out_any   = m_data_reg[MAP_W + COUNT_W];
    assign out_angle = m_data_reg[MAP_W + COUNT_W + 1 +: ANGLE_W];

    // The count must agree with the bitmap it was built alongside.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($countones(out_map) == 32'(out_count)))
        else $error("result count does not match the bitmap");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_any == (out_count != '0)))
        else $error("any_online disagrees with the count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((out_angle == ANGLE_W'(NO_ANGLE))
                         || (($signed(out_angle) >= -11'sd180)
                             && ($signed(out_angle) <= 11'sd179))))
        else $error("line angle outside its range");

    // Once a result is loaded the frame accumulators start from empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ((acc_map == '0) && (acc_count == '0)))
        else $error("frame accumulators not cleared after a result");

endmodule

`default_nettype wire
